### hw/rtl/ciou_pkg.sv
`timescale 1ns / 1ps

package ciou_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TAG_BITS  = 20;

  // coordinate: one integer bit over FRAC_BITS fraction bits
  localparam int CW    = FRAC_BITS + 1;
  // signed length: room for sums of several arcs and their differences
  localparam int LW    = FRAC_BITS + 4;
  // unsigned divisor and partial remainder
  localparam int DW    = FRAC_BITS + 3;
  // one quotient bit per divider cell
  localparam int NCELL = FRAC_BITS;

  typedef logic [CW-1:0]        coord_t;
  typedef logic signed [LW-1:0] len_t;
  typedef logic [DW-1:0]        dlen_t;
  typedef logic [FRAC_BITS-1:0] quo_t;
  typedef logic [TAG_BITS-1:0]  tag_t;

  localparam coord_t ONE_C = coord_t'(1) << FRAC_BITS;

  // one request as it moves down the divider chain
  typedef struct packed {
    logic  meets;
    logic  uzero;
    logic  full;
    logic  zero;
    dlen_t rem;
    dlen_t dvs;
    quo_t  quo;
    tag_t  tag;
  } work_t;

endpackage

### hw/rtl/ciou_front.sv
`timescale 1ns / 1ps

module ciou_front (
  input  ciou_pkg::coord_t a_start,
  input  ciou_pkg::coord_t a_end,
  input  ciou_pkg::coord_t b_start,
  input  ciou_pkg::coord_t b_end,
  input  ciou_pkg::tag_t   pair_tag,
  output ciou_pkg::work_t  work
);
  import ciou_pkg::*;

  localparam len_t ONE_L = len_t'(ONE_C);

  function automatic len_t sat(input coord_t c);
    coord_t v;
    v = (c > ONE_C) ? ONE_C : c;
    return $signed({{(LW-CW){1'b0}}, v});
  endfunction

  function automatic len_t mx(input len_t p, input len_t q);
    return (p > q) ? p : q;
  endfunction

  function automatic len_t mn(input len_t p, input len_t q);
    return (p < q) ? p : q;
  endfunction

  function automatic len_t pos(input len_t p);
    return (p > 0) ? p : '0;
  endfunction

  // union of a plain arc [p1,p2] and a wrapping arc [q1,1] u [0,q2]
  function automatic len_t union_mixed(input len_t p1, input len_t p2,
                                       input len_t q1, input len_t q2);
    len_t u;
    if (p1 <= q2) begin
      u = (q1 <= p2) ? ONE_L : mx(p2, q2) + ONE_L - q1;
    end else if (q1 <= p2) begin
      u = q2 + ONE_L - mn(p1, q1);
    end else begin
      u = q2 + ONE_L - q1 + p2 - p1;
    end
    return u;
  endfunction

  len_t x1, x2, y1, y2, ov, un;
  logic aw, bw, meet;

  always_comb begin
    x1 = sat(a_start);
    x2 = sat(a_end);
    y1 = sat(b_start);
    y2 = sat(b_end);
    aw = x1 > x2;
    bw = y1 > y2;

    if (!aw && !bw) begin
      meet = (x1 <= y2) && (y1 <= x2);
      ov   = mn(x2, y2) - mx(x1, y1);
      un   = mx(x2, y2) - mn(x1, y1);
    end else if (!aw) begin
      meet = (y1 <= x2) || (x1 <= y2);
      ov   = pos(x2 - mx(x1, y1)) + pos(mn(x2, y2) - x1);
      un   = union_mixed(x1, x2, y1, y2);
    end else if (!bw) begin
      meet = (x1 <= y2) || (y1 <= x2);
      ov   = pos(y2 - mx(x1, y1)) + pos(mn(x2, y2) - y1);
      un   = union_mixed(y1, y2, x1, x2);
    end else begin
      meet = 1'b1;
      ov   = pos(ONE_L - mx(x1, y1)) + pos(y2 - x1) + pos(x2 - y1) + pos(mn(x2, y2));
      un   = ((y1 <= x2) || (y2 >= x1)) ? ONE_L : ONE_L - mn(x1, y1) + mx(y2, x2);
    end

    work.meets = meet;
    work.uzero = 1'b0;
    work.full  = 1'b0;
    work.zero  = 1'b1;
    work.rem   = '0;
    work.dvs   = dlen_t'(1);
    work.quo   = '0;
    work.tag   = pair_tag;

    if (meet && (ov > 0)) begin
      if (un <= 0) begin
        work.uzero = 1'b1;
      end else if (ov >= un) begin
        work.full = 1'b1;
        work.zero = 1'b0;
      end else begin
        work.zero = 1'b0;
        work.rem  = dlen_t'(ov);
        work.dvs  = dlen_t'(un);
      end
    end
  end

endmodule

### hw/rtl/ciou_div_cell.sv
`timescale 1ns / 1ps

module ciou_div_cell (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vin,
  input  ciou_pkg::work_t pin,
  output logic            vout,
  output ciou_pkg::work_t pout
);
  import ciou_pkg::*;

  logic [DW:0] r2, dext;
  logic        ge;
  logic        vld_r;
  work_t       pay_r, pay_nxt;

  // one restoring step: double the remainder, subtract when it fits
  always_comb begin
    r2      = {pin.rem, 1'b0};
    dext    = {1'b0, pin.dvs};
    ge      = r2 >= dext;
    pay_nxt = pin;
    pay_nxt.rem = ge ? dlen_t'(r2 - dext) : dlen_t'(r2);
    pay_nxt.quo = {pin.quo[FRAC_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= vin;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pay_r <= pay_nxt;
    end
  end

  assign vout = vld_r;
  assign pout = pay_r;

endmodule

### hw/rtl/circular_interval_iou_unit.sv
`timescale 1ns / 1ps

// Intersection over union of two closed arcs on the unit circle. Each request
// carries arcs a and b as unsigned fractions with FRAC_BITS fraction bits
// (2^FRAC_BITS is 1.0, larger values saturate to 1.0); an arc whose start is
// above its end wraps through zero. The result gives out_ratio =
// floor(overlap * 2^FRAC_BITS / union), exactly 1.0 when overlap equals the
// union, and 0 when the arcs miss or only touch. out_meets flags any contact,
// out_union_zero flags an empty union (ratio then 0), and the tag comes back
// unchanged. Throughput is one request per cycle while the output is not
// stalled. A request passes through one register after the arc geometry and
// one cell per quotient bit in the restoring divider chain, the last cell
// serving as the output register. Each stage advances when the next one is
// empty or moving, so bubbles close up and in_stall rises only when every
// stage holds a request and the output is stalled.
module circular_interval_iou_unit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  ciou_pkg::coord_t in_a_start,
  input  ciou_pkg::coord_t in_a_end,
  input  ciou_pkg::coord_t in_b_start,
  input  ciou_pkg::coord_t in_b_end,
  input  ciou_pkg::tag_t   in_pair_tag,
  output logic             out_valid,
  input  logic             out_stall,
  output ciou_pkg::coord_t out_ratio,
  output logic             out_meets,
  output logic             out_union_zero,
  output ciou_pkg::tag_t   out_tag_out
);
  import ciou_pkg::*;

  // front end: wrap cases, contact test, overlap and union lengths
  work_t front_w;

  ciou_front u_front (
    .a_start  (in_a_start),
    .a_end    (in_a_end),
    .b_start  (in_b_start),
    .b_end    (in_b_end),
    .pair_tag (in_pair_tag),
    .work     (front_w)
  );

  // stage 0 holds the front end's result; stage k is divider cell k-1
  logic         s0_vld_r;
  work_t        s0_pay_r;
  logic         cv [NCELL+1];
  work_t        cp [NCELL+1];
  logic [NCELL:0] en;
  work_t        last_w;

  // advance a stage when it is empty or its successor advances
  always_comb begin
    en[NCELL] = !cv[NCELL] || !out_stall;
    for (int k = NCELL - 1; k >= 0; k--) begin
      en[k] = !cv[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en[0]) begin
      s0_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_pay_r <= front_w;
    end
  end

  assign cv[0] = s0_vld_r;
  assign cp[0] = s0_pay_r;

  // divider chain: each cell settles one quotient bit, MSB first
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    ciou_div_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en[g+1]),
      .vin   (cv[g]),
      .pin   (cp[g]),
      .vout  (cv[g+1]),
      .pout  (cp[g+1])
    );
  end

  // pick the final ratio: zero for misses, touches and empty unions, one for full overlap, else quotient
  assign last_w         = cp[NCELL];
  assign out_valid      = cv[NCELL];
  assign out_ratio      = last_w.zero ? '0 :
                          last_w.full ? ONE_C : coord_t'(last_w.quo);
  assign out_meets      = last_w.meets;
  assign out_union_zero = last_w.uzero;
  assign out_tag_out    = last_w.tag;

  // an empty union only arises for arcs that meet, and gives ratio zero
  a_uzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_union_zero |-> out_meets && (out_ratio == '0))
    else $error("union-zero result carries a ratio or no contact");

  // disjoint arcs never report overlap
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_meets |-> (out_ratio == '0))
    else $error("non-meeting arcs gave a nonzero ratio");

  // the ratio never exceeds one
  a_ratio_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ratio <= ONE_C))
    else $error("ratio above one");

  // back-pressure only when the chain is blocked at its tail
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_vld_r && out_valid && out_stall)
    else $error("input stalled while the chain could move");

endmodule
